### design/rwmc_pkg.sv
package rwmc_pkg;

    typedef struct packed {
        logic       operation;
        logic [1:0] direction;
    } in_t;

    typedef struct packed {
        logic        moved;
        logic        carved;
        logic [5:0]  from_row;
        logic [5:0]  from_col;
        logic [1:0]  wall_side;
        logic [5:0]  walker_row;
        logic [5:0]  walker_col;
        logic [12:0] included_count;
        logic        done_res;
    } out_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_MARK
    } state_t;

    localparam logic OP_STEP    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [1:0] DIR_WEST  = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_NORTH = 2'd2;
    localparam logic [1:0] DIR_SOUTH = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_COL = 2'd3;

    localparam logic [6:0] GRID_ROWS_RST = 7'd10;
    localparam logic [6:0] GRID_COLS_RST = 7'd10;
    localparam logic [6:0] GRID_MIN      = 7'd2;

    localparam logic [12:0] COUNT_MAX = 13'd8191;

endpackage

### design/random_walk_maze_carver_core.sv
// Step: an in-grid step reads its visited row at transfer; the read-modify-write state
// then marks the cell if new and loads the result register once the output is free. A step
// that leaves the grid loads the result register at transfer. Restart: one row of the visited
// memory cleared per cycle, then the start cell is marked. One item is in work at a time;
// the output register frees s_ready. Reset (aresetn low, synchronous) clears control state
// and then runs a clearing pass over the visited memory, during which s_ready stays low.
module random_walk_maze_carver_core #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rwmc_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rwmc_pkg::out_t                   m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rwmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int PW0 = (RW > CW) ? RW : CW;
    localparam int PW  = ((PW0 > 7) ? PW0 : 7) + 1;
    localparam logic [8:0]    MaxRowsExt = 9'(MAX_ROWS);
    localparam logic [8:0]    MaxColsExt = 9'(MAX_COLS);
    localparam logic [RW-1:0] LastRow    = RW'(MAX_ROWS - 1);
    localparam logic [MAX_COLS-1:0] ColOne = {{(MAX_COLS-1){1'b0}}, 1'b1};

    rwmc_pkg::state_t state_reg, state_next;
    logic [RW-1:0]    clr_row_reg, clr_row_next;
    logic             restart_reg, restart_next;
    logic [RW-1:0]    walker_row_reg, walker_row_next;
    logic [CW-1:0]    walker_col_reg, walker_col_next;
    logic [12:0]      count_reg, count_next;
    logic [RW-1:0]    tgt_row_reg, tgt_row_next;
    logic [CW-1:0]    tgt_col_reg, tgt_col_next;
    logic [1:0]       dir_reg, dir_next;
    logic             out_valid_reg, out_valid_next;
    rwmc_pkg::out_t   out_data_reg, out_data_next;

    logic [6:0] grid_rows_reg, grid_cols_reg;
    logic [5:0] start_row_reg, start_col_reg;

    logic [6:0]  rows_use, cols_use;
    logic [6:0]  start_row_use, start_col_use;
    logic [13:0] area;
    logic        out_free;
    logic        s_fire;
    logic [PW-1:0] fr, fc, tr, tc;
    logic          step_ok, in_grid;

    logic                rd_en, wr_en;
    logic [RW-1:0]       rd_addr, wr_addr;
    logic [MAX_COLS-1:0] rd_data, wr_data;

    rwmc_visit_ram #(
        .DEPTH (MAX_ROWS),
        .WIDTH (MAX_COLS)
    ) u_visit_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= rwmc_pkg::GRID_ROWS_RST;
            grid_cols_reg <= rwmc_pkg::GRID_COLS_RST;
            start_row_reg <= '0;
            start_col_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rwmc_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                rwmc_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_data;
                rwmc_pkg::REG_START_ROW: start_row_reg <= cfg_data[5:0];
                rwmc_pkg::REG_START_COL: start_col_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // grid size in use and clamped start cell
    always_comb begin
        if (grid_rows_reg < rwmc_pkg::GRID_MIN) begin
            rows_use = rwmc_pkg::GRID_MIN;
        end else if ({2'b00, grid_rows_reg} > MaxRowsExt) begin
            rows_use = 7'(MAX_ROWS);
        end else begin
            rows_use = grid_rows_reg;
        end
        if (grid_cols_reg < rwmc_pkg::GRID_MIN) begin
            cols_use = rwmc_pkg::GRID_MIN;
        end else if ({2'b00, grid_cols_reg} > MaxColsExt) begin
            cols_use = 7'(MAX_COLS);
        end else begin
            cols_use = grid_cols_reg;
        end
        start_row_use = ({1'b0, start_row_reg} > rows_use - 7'd1) ? rows_use - 7'd1
                                                                   : {1'b0, start_row_reg};
        start_col_use = ({1'b0, start_col_reg} > cols_use - 7'd1) ? cols_use - 7'd1
                                                                   : {1'b0, start_col_reg};
        area = 14'(rows_use) * 14'(cols_use);
    end

    // step target from the current walker position
    always_comb begin
        fr      = PW'(walker_row_reg);
        fc      = PW'(walker_col_reg);
        tr      = fr;
        tc      = fc;
        step_ok = 1'b1;
        unique case (s_data.direction)
            rwmc_pkg::DIR_WEST: begin
                step_ok = (fc != '0);
                tc      = fc - PW'(1);
            end
            rwmc_pkg::DIR_EAST: begin
                tc = fc + PW'(1);
            end
            rwmc_pkg::DIR_NORTH: begin
                step_ok = (fr != '0);
                tr      = fr - PW'(1);
            end
            rwmc_pkg::DIR_SOUTH: begin
                tr = fr + PW'(1);
            end
            default: ;
        endcase
        in_grid = step_ok && (tr < PW'(rows_use)) && (tc < PW'(cols_use));
    end

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == rwmc_pkg::ST_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        clr_row_next    = clr_row_reg;
        restart_next    = restart_reg;
        walker_row_next = walker_row_reg;
        walker_col_next = walker_col_reg;
        count_next      = count_reg;
        tgt_row_next    = tgt_row_reg;
        tgt_col_next    = tgt_col_reg;
        dir_next        = dir_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_data_next   = out_data_reg;
        rd_en           = 1'b0;
        rd_addr         = RW'(tr);
        wr_en           = 1'b0;
        wr_addr         = clr_row_reg;
        wr_data         = '0;

        out_data_next.from_row  = fr[5:0];
        out_data_next.from_col  = fc[5:0];
        out_data_next.moved     = 1'b0;
        out_data_next.carved    = 1'b0;
        out_data_next.wall_side = rwmc_pkg::DIR_WEST;

        unique case (state_reg)
            rwmc_pkg::ST_CLEAR: begin
                wr_en = 1'b1;
                if (clr_row_reg == LastRow) begin
                    clr_row_next = '0;
                    state_next   = restart_reg ? rwmc_pkg::ST_MARK : rwmc_pkg::ST_IDLE;
                end else begin
                    clr_row_next = clr_row_reg + RW'(1);
                end
            end
            rwmc_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.operation == rwmc_pkg::OP_RESTART) begin
                        restart_next = 1'b1;
                        clr_row_next = '0;
                        state_next   = rwmc_pkg::ST_CLEAR;
                    end else if (in_grid) begin
                        rd_en        = 1'b1;
                        tgt_row_next = RW'(tr);
                        tgt_col_next = CW'(tc);
                        dir_next     = s_data.direction;
                        state_next   = rwmc_pkg::ST_RMW;
                    end else begin
                        // rejected step: walker and count hold
                        out_valid_next = 1'b1;
                    end
                end
            end
            rwmc_pkg::ST_RMW: begin
                if (out_free) begin
                    out_valid_next       = 1'b1;
                    out_data_next.moved  = 1'b1;
                    walker_row_next      = tgt_row_reg;
                    walker_col_next      = tgt_col_reg;
                    if (!rd_data[tgt_col_reg]) begin
                        wr_en                   = 1'b1;
                        wr_addr                 = tgt_row_reg;
                        wr_data                 = rd_data | (ColOne << tgt_col_reg);
                        out_data_next.carved    = 1'b1;
                        out_data_next.wall_side = dir_reg;
                        if (count_reg != rwmc_pkg::COUNT_MAX) begin
                            count_next = count_reg + 13'd1;
                        end
                    end
                    state_next = rwmc_pkg::ST_IDLE;
                end
            end
            rwmc_pkg::ST_MARK: begin
                if (out_free) begin
                    // memory rows are all zero here, so write the start row without a read
                    wr_en           = 1'b1;
                    wr_addr         = RW'(start_row_use);
                    wr_data         = ColOne << CW'(start_col_use);
                    walker_row_next = RW'(start_row_use);
                    walker_col_next = CW'(start_col_use);
                    count_next      = 13'd1;
                    restart_next    = 1'b0;
                    out_valid_next  = 1'b1;
                    state_next      = rwmc_pkg::ST_IDLE;
                end
            end
            default: ;
        endcase

        out_data_next.walker_row     = 6'(walker_row_next);
        out_data_next.walker_col     = 6'(walker_col_next);
        out_data_next.included_count = count_next;
        out_data_next.done_res       = ({1'b0, count_next} >= area);
        if (!(out_valid_next && !(out_valid_reg && !m_ready))) begin
            out_data_next = out_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rwmc_pkg::ST_CLEAR;
            clr_row_reg    <= '0;
            restart_reg    <= 1'b0;
            walker_row_reg <= '0;
            walker_col_reg <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_row_reg    <= clr_row_next;
            restart_reg    <= restart_next;
            walker_row_reg <= walker_row_next;
            walker_col_reg <= walker_col_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tgt_row_reg  <= tgt_row_next;
        tgt_col_reg  <= tgt_col_next;
        dir_reg      <= dir_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

### design/rwmc_visit_ram.sv
module rwmc_visit_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] visit_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            visit_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= visit_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/rwmc_checker.sv
module rwmc_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input rwmc_pkg::in_t   s_data,
    input logic            m_valid,
    input logic            m_ready,
    input rwmc_pkg::out_t  m_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a restart starts the clearing pass, so no transfer is taken next cycle
    a_restart_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.operation == rwmc_pkg::OP_RESTART) |=> !s_ready)
        else $error("input taken during clearing pass");

    // a carve implies a move; otherwise no wall side is reported
    a_carve_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.moved ||
                    (!m_data.carved && (m_data.wall_side == rwmc_pkg::DIR_WEST)))
        else $error("carve or wall side without a move");

    a_carve_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.carved |-> (m_data.included_count != 13'd0))
        else $error("carve with an empty count");

    // the clearing pass after reset blocks input
    a_reset_clear: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !s_ready)
        else $error("input ready right after reset");

endmodule

bind random_walk_maze_carver_core rwmc_checker u_rwmc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
